FILE: rtl/lwsc_pkg.sv
// ---------------------------------------------------------------------------
// lwsc_pkg: shared types and constants
// request codes and widths of the sector cache tag controller
// ---------------------------------------------------------------------------
package lwsc_pkg;
  localparam int SLOT_COUNT  = 64;
  localparam int SECTOR_BITS = 32;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);

  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] sector;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  slot;
    logic        writeback_valid;
    logic [31:0] writeback_sector;
    logic        fill_valid;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic        last;
  } rsp_t;
endpackage

FILE: rtl/lwsc_if.sv
// ---------------------------------------------------------------------------
// lwsc_if: valid/ready channel
// carries one request or one result per handshake
// ---------------------------------------------------------------------------
interface lwsc_req_if;
  logic valid;
  logic ready;
  lwsc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lwsc_rsp_if;
  logic valid;
  logic ready;
  lwsc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lru_writeback_sector_cache_tags_top.sv
// ---------------------------------------------------------------------------
// lru_writeback_sector_cache_tags_top: tag/valid/dirty/lru controller
// read/write: tag memory scanned one slot a cycle, then compare and update load the result
// the next request is taken once the controller is back in idle, so lookups never overlap
// flush: ranks swept in order, one result per dirty write-back, last result at sweep end
// result stalls stretch lookups and flushes; a held result only delays the end of a request
// synchronous active-low reset clears valid, dirty and counters and resets ranks
// ---------------------------------------------------------------------------
module lru_writeback_sector_cache_tags_top (
  input logic clk,
  input logic rst_n,
  lwsc_req_if.sink   in_req,
  lwsc_rsp_if.source out_rsp
);
  import lwsc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;  // tag memory read one slot a cycle
  localparam logic [2:0] ST_CMP   = 3'd2;  // last compare and update
  localparam logic [2:0] ST_FLUSH = 3'd3;  // sweep ranks in order
  localparam logic [2:0] ST_FLRD  = 3'd4;  // tag read for write-back

  localparam logic [SLOT_W-1:0] LAST_RANK = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  // tag store in a synchronous memory, one read port, one write port
  logic [SECTOR_BITS-1:0] tag_mem [SLOT_COUNT];
  logic [SECTOR_BITS-1:0] tag_rd_r;
  logic [SLOT_W-1:0]      tag_ra;
  logic                   tag_we;
  logic [SLOT_W-1:0]      tag_wa;
  logic [SECTOR_BITS-1:0] tag_wd;

  // valid, dirty, rank per slot in flip-flops
  logic [SLOT_COUNT-1:0] valid_r, dirty_r;
  logic [SLOT_W-1:0]     rank_r [SLOT_COUNT];
  logic [31:0]           hit_cnt_r, miss_cnt_r;

  logic [2:0]             state_r;
  logic [1:0]             type_r;
  logic [SECTOR_BITS-1:0] sec_r;
  logic [SLOT_W-1:0]      scan_idx_r;   // address being read
  logic [SLOT_W-1:0]      cmp_idx_r;    // address whose tag sits in tag_rd_r
  logic                   cmp_v_r;
  logic                   found_r;
  logic [SLOT_W-1:0]      found_slot_r;
  logic [SECTOR_BITS-1:0] victim_tag_r;
  logic [SLOT_W:0]        rank_ptr_r;   // sweep position, one wider
  logic [SLOT_W-1:0]      fl_slot_r;
  logic [SECTOR_BITS-1:0] fl_tag_r;
  logic                   fl_any_r;
  rsp_t                   rsp_r;
  logic                   rsp_v_r;

  logic                   res_free;
  logic                   sweep_done;
  logic                   rsp_load;
  rsp_t                   rsp_d;

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_rd_r <= tag_mem[tag_ra];
  end

  // victim: slot holding the oldest rank
  logic [SLOT_W-1:0] victim;
  always_comb begin
    victim = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (rank_r[i] == LAST_RANK) victim = SLOT_W'(i);
    end
  end

  // compare of the tag that just came out of memory
  logic                   cmp_hit;
  logic                   hit_any;
  logic [SLOT_W-1:0]      hit_slot;
  logic [SLOT_W-1:0]      srv;
  logic [SECTOR_BITS-1:0] vtag;
  logic                   wb_need;
  assign cmp_hit  = cmp_v_r && valid_r[cmp_idx_r] && (tag_rd_r == sec_r);
  assign hit_any  = found_r || cmp_hit;
  assign hit_slot = found_r ? found_slot_r : cmp_idx_r;
  assign srv      = hit_any ? hit_slot : victim;
  assign vtag     = (cmp_v_r && cmp_idx_r == victim) ? tag_rd_r : victim_tag_r;
  assign wb_need  = valid_r[victim] && dirty_r[victim];

  // next dirty slot at the current sweep rank
  logic                  fl_found;
  logic [SLOT_W-1:0]     fl_slot;
  always_comb begin
    fl_found = 1'b0;
    fl_slot  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (rank_r[i] == rank_ptr_r[SLOT_W-1:0] && valid_r[i] && dirty_r[i]) begin
        fl_found = 1'b1;
        fl_slot  = SLOT_W'(i);
      end
    end
  end

  assign sweep_done = rank_ptr_r[SLOT_W];
  assign res_free   = !rsp_v_r || out_rsp.ready;

  // a request is taken whenever the controller is idle; a held result only
  // delays the point where the next result is written
  assign in_req.ready  = (state_r == ST_IDLE);
  assign out_rsp.valid = rsp_v_r;
  assign out_rsp.data  = rsp_r;

  // read address: scan position, flush candidate, else the last compare address
  always_comb begin
    case (state_r)
      ST_SCAN:  tag_ra = scan_idx_r;
      ST_FLUSH: tag_ra = fl_slot;
      default:  tag_ra = cmp_idx_r;
    endcase
  end

  always_comb begin
    tag_we = (state_r == ST_CMP) && res_free && !hit_any;
    tag_wa = victim;
    tag_wd = sec_r;
  end

  // result load points: end of a lookup, a held write-back pushed out by
  // the next dirty slot, or the end of a flush
  assign rsp_load = res_free &&
                    ((state_r == ST_CMP) ||
                     (state_r == ST_FLUSH && (sweep_done || (fl_found && fl_any_r))));

  always_comb begin
    rsp_d      = '0;
    rsp_d.last = 1'b1;
    if (state_r == ST_CMP) begin
      rsp_d.hit              = hit_any;
      rsp_d.slot             = srv;
      rsp_d.writeback_valid  = !hit_any && wb_need;
      rsp_d.writeback_sector = (!hit_any && wb_need) ? vtag : '0;
      rsp_d.fill_valid       = !hit_any;
      rsp_d.hit_total        = hit_cnt_r + {31'd0, hit_any};
      rsp_d.miss_total       = miss_cnt_r + {31'd0, !hit_any};
    end else if (fl_any_r) begin
      // held write-back; last only when the sweep is over
      rsp_d.slot             = fl_slot_r;
      rsp_d.writeback_valid  = 1'b1;
      rsp_d.writeback_sector = fl_tag_r;
      rsp_d.last             = sweep_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rsp_v_r    <= 1'b0;
      valid_r    <= '0;
      dirty_r    <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      rank_ptr_r <= '0;
      fl_any_r   <= 1'b0;
      cmp_v_r    <= 1'b0;
      found_r    <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) rank_r[i] <= SLOT_W'(SLOT_COUNT - 1 - i);
    end else begin
      if (rsp_load) begin
        rsp_v_r <= 1'b1;
        rsp_r   <= rsp_d;
      end else if (out_rsp.ready) begin
        rsp_v_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_req.valid && in_req.ready) begin
            type_r     <= in_req.data.req_type;
            sec_r      <= in_req.data.sector[SECTOR_BITS-1:0];
            scan_idx_r <= '0;
            cmp_v_r    <= 1'b0;
            found_r    <= 1'b0;
            rank_ptr_r <= '0;
            fl_any_r   <= 1'b0;
            if (in_req.data.req_type == REQ_FLUSH) begin
              state_r <= ST_FLUSH;
            end else if (in_req.data.req_type != REQ_UNUSED) begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // first valid match in slot order wins
          cmp_v_r   <= 1'b1;
          cmp_idx_r <= scan_idx_r;
          if (cmp_hit && !found_r) begin
            found_r      <= 1'b1;
            found_slot_r <= cmp_idx_r;
          end
          if (cmp_v_r && cmp_idx_r == victim) victim_tag_r <= tag_rd_r;
          if (scan_idx_r == LAST_SLOT) begin
            state_r <= ST_CMP;
          end else begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
        end
        ST_CMP: begin
          if (res_free) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (SLOT_W'(i) == srv) begin
                rank_r[i] <= '0;
              end else if (rank_r[i] < rank_r[srv]) begin
                rank_r[i] <= rank_r[i] + 1'b1;
              end
            end
            if (hit_any) begin
              hit_cnt_r <= hit_cnt_r + 1'b1;
              if (type_r == REQ_WRITE) dirty_r[srv] <= 1'b1;
            end else begin
              miss_cnt_r   <= miss_cnt_r + 1'b1;
              valid_r[srv] <= 1'b1;
              dirty_r[srv] <= (type_r == REQ_WRITE);
            end
            state_r <= ST_IDLE;
          end
        end
        ST_FLUSH: begin
          if (sweep_done) begin
            if (res_free) begin
              // close the flush: last write-back or a lone empty result
              valid_r    <= '0;
              dirty_r    <= '0;
              hit_cnt_r  <= '0;
              miss_cnt_r <= '0;
              for (int i = 0; i < SLOT_COUNT; i++)
                rank_r[i] <= SLOT_W'(SLOT_COUNT - 1 - i);
              state_r <= ST_IDLE;
            end
          end else if (fl_found) begin
            // the held slot goes out before the new one is taken
            if (!fl_any_r || res_free) begin
              fl_slot_r <= fl_slot;
              state_r   <= ST_FLRD;
            end
          end else begin
            rank_ptr_r <= rank_ptr_r + 1'b1;
          end
        end
        ST_FLRD: begin
          fl_tag_r   <= tag_rd_r;
          fl_any_r   <= 1'b1;
          rank_ptr_r <= rank_ptr_r + 1'b1;
          state_r    <= ST_FLUSH;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_req.ready) else $error("ready while busy");
  a_cmp_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP && res_free) |=> rsp_v_r) else $error("lookup lost its result");
  a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
    (rsp_v_r && !out_rsp.ready) |=> (rsp_v_r && $stable(rsp_r)))
    else $error("result changed while stalled");
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && sweep_done && res_free) |=> (valid_r == '0 && hit_cnt_r == '0))
    else $error("flush left valid slots");
`endif
endmodule
